// ----- design/rank_count_sorted_store_core_defines.svh -----
// assertion macros shared by the rank count sorted store design
// no dependencies; included by the files that carry assertions
`ifndef RANK_COUNT_SORTED_STORE_CORE_DEFINES_SVH
`define RANK_COUNT_SORTED_STORE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCSS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcss assertion failed");

// next-cycle implication, disabled during reset
`define RCSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcss assertion failed");

`endif

// ----- design/rcss_pkg.sv -----
// types and codes for the rank count sorted store
// no dependencies
package rcss_pkg;

   // operation codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   localparam int COUNT_OUT_W = 11;
   localparam int VALUE_W     = 32;

   // request beat
   typedef struct packed {
      logic [1:0]                func;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   // response beat
   typedef struct packed {
      logic [COUNT_OUT_W-1:0] count_not_above;
      logic                   full_flag;
   } rsp_type;

   // finished result offered by the sequencer to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

endpackage

// ----- design/rcss_mem.sv -----
// value store: one write port, one read port with registered read data
// depends on nothing
module rcss_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/rcss_ctrl.sv -----
// sequencer: binary search with a shared compare unit, then entry shifting on insert
// depends on rcss_pkg, rcss_mem and the assertion macro header
`include "rank_count_sorted_store_core_defines.svh"

module rcss_ctrl #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rcss_pkg::req_type req,
   output logic              idle,
   output rcss_pkg::done_type done,
   input  logic              done_take
);
   import rcss_pkg::*;

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SRCH = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_SHRD = 3'd3;
   localparam logic [2:0] ST_SHWR = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic                      is_query_ff, is_query_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi_ff, hi_in;
   logic [CNT_W-1:0]          mid_ff, mid_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      sticky_ff, sticky_in;

   logic [CNT_W-1:0]          mid_calc;
   logic [CNT_W-1:0]          idx_dec;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [VALUE_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]         mem_raddr;
   logic [VALUE_W-1:0]        mem_rdata;

   rcss_mem #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // midpoint of the live search window and shift index step
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec  = idx_ff - CNT_W'(1);

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      is_query_in = is_query_ff;
      value_in    = value_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      sticky_in   = sticky_ff;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff[ADDR_W-1:0];
      mem_wdata   = mem_rdata;
      mem_raddr   = mid_calc[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in    = req.value;
               is_query_in = (req.func == FUNC_QUERY);
               case (req.func)
                  FUNC_CLEAR: begin
                     count_in  = '0;
                     sticky_in = 1'b0;
                  end
                  FUNC_INSERT: begin
                     if (count_ff >= CNT_W'(STORE_DEPTH)) begin
                        sticky_in = 1'b1;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = ST_SRCH;
                     end
                  end
                  FUNC_QUERY: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = ST_SRCH;
                  end
                  default: ;
               endcase
            end
         end
         // issue the midpoint read, or finish the search
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mem_raddr = mid_calc[ADDR_W-1:0];
               mid_in    = mid_calc;
               state_in  = ST_CMP;
            end else if (is_query_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = count_ff;
               state_in = ST_SHRD;
            end
         end
         // shared compare narrows the window
         ST_CMP: begin
            if ($signed(mem_rdata) <= value_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SRCH;
         end
         // read the entry below the hole, or drop the new value into it
         ST_SHRD: begin
            if (idx_ff > lo_ff) begin
               mem_raddr = idx_dec[ADDR_W-1:0];
               state_in  = ST_SHWR;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = lo_ff[ADDR_W-1:0];
               mem_wdata = value_ff;
               count_in  = count_ff + CNT_W'(1);
               state_in  = ST_IDLE;
            end
         end
         // move that entry up by one
         ST_SHWR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            idx_in    = idx_dec;
            state_in  = ST_SHRD;
         end
         // hold the query result until the output stage takes it
         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         sticky_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      is_query_ff <= is_query_in;
      value_ff    <= value_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
   end

   // count wraps to the response field width
   assign count_ext = (CNT_W + COUNT_OUT_W)'(lo_ff);

   assign idle                       = (state_ff == ST_IDLE);
   assign done.valid                 = (state_ff == ST_DONE);
   assign done.rsp.count_not_above   = count_ext[COUNT_OUT_W-1:0];
   assign done.rsp.full_flag         = sticky_ff;

   `RCSS_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STORE_DEPTH))
   `RCSS_ASSERT_HOLDS(a_mid_in_window, clock, reset, state_ff == ST_CMP, lo_ff <= mid_ff && mid_ff < hi_ff)
   `RCSS_ASSERT_HOLDS(a_write_only_insert, clock, reset, mem_we, (state_ff == ST_SHRD || state_ff == ST_SHWR) && !is_query_ff)
   `RCSS_ASSERT_NEXT(a_full_sets_sticky, clock, reset, start && idle && req.func == FUNC_INSERT && count_ff == CNT_W'(STORE_DEPTH), sticky_ff && $stable(count_ff))
   `RCSS_ASSERT_NEXT(a_done_holds, clock, reset, done.valid && !done_take, done.valid && $stable(lo_ff))

endmodule

// ----- design/rank_count_sorted_store_core.sv -----
// Sorted rank store: a request channel takes clear, insert and query beats;
// the response channel returns one beat per query with the rank count and the
// full flag. A clear, an ignored code, or an insert into a full store is done
// in the idle state, with no search. A query binary-searches the stored values
// with one compare unit, each step a memory read, then a compare. An insert
// does the same search and then moves every entry above the insert position
// up one slot, each by a read and then a write, then writes the new value.
// req_ready is high only while the sequencer is idle; one item is in work at a time.
// Responses sit in an output register; a clear or insert may be accepted while
// a response waits. A finished query holds the sequencer until the register
// frees, so a stalled receiver backs up onto the request channel.
// Reset (synchronous, active high) empties the store and clears the full flag.
// No clearing pass is needed: only entries below the stored count are read.
// depends on rcss_pkg, rcss_ctrl, rcss_mem
module rank_count_sorted_store_core #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcss_pkg::rsp_type rsp_data
);
   import rcss_pkg::*;

   logic     start;
   logic     idle;
   done_type done;
   logic     done_take;

   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   rcss_ctrl #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .idle      (idle),
      .done      (done),
      .done_take (done_take)
   );

   // request beat accepted only while the sequencer is idle
   assign req_ready = idle;
   assign start     = req_valid && idle;

   // output register loads when empty or draining this cycle
   assign done_take = done.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
